// File: design/kdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debounce and long-press core.
// ----------------------------------------------------------------------------
package kdlp_pkg;

  // field and register widths
  localparam int TICK_W  = 8;
  localparam int STAB_W  = 8;
  localparam int THR_W   = 12;
  localparam int HOLD_W  = THR_W + 1;
  localparam int EV_W    = 2;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 12;

  // register reset values
  localparam logic [TICK_W-1:0] PRESCALE_RST = 8'd5;
  localparam logic [STAB_W-1:0] DEBOUNCE_RST = 8'd8;
  localparam logic [THR_W-1:0]  LONG_RST     = 12'd300;
  localparam logic [THR_W-1:0]  TEST_RST     = 12'd400;

  // scan state
  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_CHECK    = 2'd1,
    ST_DEBOUNCE = 2'd2,
    ST_HELD     = 2'd3
  } scan_state_t;

  // key event codes
  typedef enum logic [EV_W-1:0] {
    EV_SHORT   = 2'd0,
    EV_LONG    = 2'd1,
    EV_RELEASE = 2'd2,
    EV_TEST    = 2'd3
  } key_event_t;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_PRESCALE = 3'd0,
    CFG_DEBOUNCE = 3'd1,
    CFG_LONG     = 3'd2,
    CFG_TEST     = 3'd3
  } cfg_index_t;

endpackage

// File: design/key_debounce_long_press_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_long_press_core
// Debounce and short/long/test press detector for one active-low key.
// ----------------------------------------------------------------------------
// Each input transaction is one base tick carrying the sampled key level. A
// prescaler runs one scan step every prescale_ticks ticks; the scan debounces
// press and release and reports short press, long press, test press and
// release-after-long-or-test events, at most one result transaction per tick.
// The core takes one tick per clock cycle while its output register is free
// or draining: the whole scan update is done in the accepting cycle and the
// event lands in a single output register, whose ready is passed back so a
// tick is taken in the same cycle the previous event is taken.
module key_debounce_long_press_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // tick channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_key_level,
  // event channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kdlp_pkg::EV_W-1:0]       out_key_event,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [kdlp_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [kdlp_pkg::CDATA_W-1:0]    cfg_wdata
);
  import kdlp_pkg::*;

  // configuration registers
  logic [TICK_W-1:0] prescale_r;
  logic [STAB_W-1:0] debounce_r;
  logic [THR_W-1:0]  long_thr_r;
  logic [THR_W-1:0]  test_thr_r;

  // scan state
  logic [TICK_W-1:0] tick_r,   tick_nxt;
  scan_state_t       state_r,  state_nxt;
  logic [STAB_W-1:0] stable_r, stable_nxt;
  logic [HOLD_W-1:0] hold_r,   hold_nxt;
  logic              long_seen_r, long_seen_nxt;

  // output register
  logic              out_valid_r;
  key_event_t        out_ev_r;

  logic              in_acc;
  logic              ev_fire;
  key_event_t        ev_code;
  logic [TICK_W-1:0] tick_inc;
  logic              scan_go;
  logic              pressed;
  logic [STAB_W-1:0] stable_inc;
  logic [HOLD_W-1:0] hold_inc;
  logic [HOLD_W-1:0] test_ext;
  logic [HOLD_W-1:0] long_ext;

  assign in_ready      = !out_valid_r || out_ready;
  assign in_acc        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_key_event = out_ev_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= PRESCALE_RST;
      debounce_r <= DEBOUNCE_RST;
      long_thr_r <= LONG_RST;
      test_thr_r <= TEST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESCALE: prescale_r <= cfg_wdata[TICK_W-1:0];
        CFG_DEBOUNCE: debounce_r <= cfg_wdata[STAB_W-1:0];
        CFG_LONG:     long_thr_r <= cfg_wdata[THR_W-1:0];
        CFG_TEST:     test_thr_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // prescaler and scan step
  always_comb begin
    pressed    = !in_key_level;
    tick_inc   = (tick_r == {TICK_W{1'b1}}) ? tick_r : tick_r + 1'b1;
    scan_go    = (tick_inc >= prescale_r);
    stable_inc = stable_r + 1'b1;
    hold_inc   = hold_r + 1'b1;
    test_ext   = {1'b0, test_thr_r};
    long_ext   = {1'b0, long_thr_r};

    tick_nxt      = scan_go ? '0 : tick_inc;
    state_nxt     = state_r;
    stable_nxt    = stable_r;
    hold_nxt      = hold_r;
    long_seen_nxt = long_seen_r;
    ev_fire       = 1'b0;
    ev_code       = EV_SHORT;

    if (scan_go) begin
      unique case (state_r)
        ST_IDLE: begin
          stable_nxt    = '0;
          long_seen_nxt = 1'b0;
          hold_nxt      = HOLD_W'(1);
          state_nxt     = ST_CHECK;
        end
        ST_CHECK: begin
          if (pressed) begin
            stable_nxt = '0;
            state_nxt  = ST_DEBOUNCE;
          end
        end
        ST_DEBOUNCE: begin
          if (pressed) begin
            stable_nxt = stable_inc;
            if (stable_inc >= debounce_r) begin
              stable_nxt = '0;
              state_nxt  = ST_HELD;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        ST_HELD: begin
          if (pressed) begin
            stable_nxt = '0;
            // hold counter stops once past the test threshold
            if (hold_r <= test_ext) begin
              hold_nxt = hold_inc;
              if (hold_inc > test_ext) begin
                ev_fire = 1'b1;
                ev_code = EV_TEST;
              end else if (hold_inc > long_ext && !long_seen_r) begin
                long_seen_nxt = 1'b1;
                ev_fire       = 1'b1;
                ev_code       = EV_LONG;
              end
            end
          end else begin
            stable_nxt = stable_inc;
            if (stable_inc >= debounce_r) begin
              stable_nxt = '0;
              state_nxt  = ST_IDLE;
              ev_fire    = 1'b1;
              ev_code    = (long_seen_r || hold_r > test_ext) ? EV_RELEASE : EV_SHORT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      state_r     <= ST_IDLE;
      stable_r    <= '0;
      hold_r      <= '0;
      long_seen_r <= 1'b0;
    end else if (in_acc) begin
      tick_r      <= tick_nxt;
      state_r     <= state_nxt;
      stable_r    <= stable_nxt;
      hold_r      <= hold_nxt;
      long_seen_r <= long_seen_nxt;
    end
  end

  // event output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && ev_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && ev_fire) begin
      out_ev_r <= ev_code;
    end
  end

  // checks
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_hold_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r <= HOLD_W'(1 << THR_W))
    else $error("hold counter past saturation");

  a_event_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ev_fire) |=> (out_valid_r && out_ev_r == $past(ev_code)))
    else $error("event not captured in output register");

  a_release_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ev_fire && (ev_code == EV_SHORT || ev_code == EV_RELEASE))
      |=> state_r == ST_IDLE)
    else $error("release event without return to idle");

endmodule

// File: tb/tb_key_debounce_long_press_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_long_press_core
// Self-checking bench for the key debounce and long-press core.
// ----------------------------------------------------------------------------
// Ticks carrying the key level go in over a valid/ready channel in random
// bursts. Each accepted tick is run through a local scan predictor, and the
// key events it produces are queued. A checker compares every event the core
// hands out against the oldest queued one. Directed cases cover zero and full
// register values, saturation of the hold count, test-before-long ordering, a
// threshold lowered while the key is held and writes to unused indexes. A
// long receiver hold-off fills the core, then random press sequences run
// under many register settings.
module tb_key_debounce_long_press_core;
  import kdlp_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RANDOM_TICKS   = 300;
  localparam int SETTLE_CYCLES  = 3;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CFG_SPARE_LO   = 4;
  localparam int MAX_REPORTS    = 200;
  localparam int HOLD_OFF_LEN   = 300;

  // receiver stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_key_level;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [EV_W-1:0]    out_key_event;
  logic               cfg_we;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_wdata;

  // predictor copy of registers and scan state
  logic [TICK_W-1:0]  pre_ticks;
  logic [STAB_W-1:0]  deb_scans;
  logic [THR_W-1:0]   long_thr;
  logic [THR_W-1:0]   test_thr;
  logic [TICK_W-1:0]  tick_cnt;
  logic [STAB_W-1:0]  stab_cnt;
  logic [HOLD_W-1:0]  hold_cnt;
  logic               long_flag;
  scan_state_t        scan_st;

  key_event_t pending_events[$];
  key_event_t want_ev;
  int         mismatch_count = 0;
  int         ticks_sent = 0;
  int         burst_left = 0;
  int         cycle_cnt = 0;

  // receiver hold-off request and pattern state
  int         hold_off_seq = 0;
  int         hold_off_seen = 0;
  int         hold_off_left = 0;
  int         rx_mode_left = 0;
  int         rx_phase = 0;
  rx_mode_t   rx_mode = RX_ALWAYS;

  key_debounce_long_press_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_level  (in_key_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_event (out_key_event),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_key_debounce_long_press_core NOT OK");
      $finish;
    end
  end

  // receiver: pattern stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_off_seq != hold_off_seen) begin
      hold_off_seen = hold_off_seq;
      hold_off_left = HOLD_OFF_LEN;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(RX_ALWAYS, RX_BURSTY));
      rx_mode_left = $urandom_range(40, 200);
    end else begin
      rx_mode_left--;
    end
    rx_phase++;
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= (rx_phase % 4) == 0;
        default:   out_ready <= (rx_phase % 16) < 3;
      endcase
    end
  end

  // event checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: key_event expected none actual %0d", $time, out_key_event);
      end else begin
        want_ev = pending_events.pop_front();
        if (out_key_event !== want_ev) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: key_event expected %0d actual %0d", $time, want_ev,
                     out_key_event);
        end
      end
    end
  end

  // one tick of the scan predictor; returns 1 when a key event comes out
  function automatic bit predict_tick(input logic level, output key_event_t ev);
    bit pressed;
    bit hit;
    pressed = (level == 1'b0);
    hit     = 1'b0;
    ev      = EV_SHORT;
    if (tick_cnt != {TICK_W{1'b1}})
      tick_cnt++;
    if (tick_cnt < pre_ticks)
      return 1'b0;
    tick_cnt = '0;
    case (scan_st)
      ST_IDLE: begin
        stab_cnt  = '0;
        long_flag = 1'b0;
        hold_cnt  = HOLD_W'(1);
        scan_st   = ST_CHECK;
      end
      ST_CHECK: begin
        if (pressed) begin
          stab_cnt = '0;
          scan_st  = ST_DEBOUNCE;
        end
      end
      ST_DEBOUNCE: begin
        if (pressed) begin
          stab_cnt = stab_cnt + 1'b1;
          if (stab_cnt >= deb_scans) begin
            stab_cnt = '0;
            scan_st  = ST_HELD;
          end
        end else begin
          scan_st = ST_IDLE;
        end
      end
      ST_HELD: begin
        if (pressed) begin
          stab_cnt = '0;
          // hold count stops one past the test threshold
          if (hold_cnt <= test_thr) begin
            hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt > test_thr) begin
              ev  = EV_TEST;
              hit = 1'b1;
            end else if (hold_cnt > long_thr && !long_flag) begin
              long_flag = 1'b1;
              ev        = EV_LONG;
              hit       = 1'b1;
            end
          end
        end else begin
          stab_cnt = stab_cnt + 1'b1;
          if (stab_cnt >= deb_scans) begin
            stab_cnt = '0;
            scan_st  = ST_IDLE;
            ev       = (long_flag || hold_cnt > test_thr) ? EV_RELEASE : EV_SHORT;
            hit      = 1'b1;
          end
        end
      end
    endcase
    return hit;
  endfunction

  // send one tick transaction, with random gaps between bursts
  task automatic send_tick(input logic level);
    key_event_t ev;
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 7);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_key_level <= level;
    do @(posedge clk); while (!in_ready);
    if (predict_tick(level, ev))
      pending_events.push_back(ev);
    ticks_sent++;
  endtask

  task automatic send_run(input logic level, input int count);
    repeat (count) send_tick(level);
  endtask

  // stop sending and let every queued event come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_PRESCALE: pre_ticks = data[TICK_W-1:0];
      CFG_DEBOUNCE: deb_scans = data[STAB_W-1:0];
      CFG_LONG:     long_thr  = data[THR_W-1:0];
      CFG_TEST:     test_thr  = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CDATA_W-1:0] pre, input logic [CDATA_W-1:0] deb,
                            input logic [CDATA_W-1:0] lng, input logic [CDATA_W-1:0] tst);
    settle();
    cfg_write(CFG_PRESCALE, pre);
    cfg_write(CFG_DEBOUNCE, deb);
    cfg_write(CFG_LONG, lng);
    cfg_write(CFG_TEST, tst);
    cfg_we <= 1'b0;
  endtask

  // reset register values, two slow scans
  task automatic test_reset_defaults();
    send_run(1'b0, 6);
    send_run(1'b1, 6);
  endtask

  // zero prescale and debounce, long then test event, hold saturation, release
  task automatic test_fast_scan_events();
    set_config(12'd0, 12'd0, 12'd2, 12'd3);
    send_run(1'b1, 2);
    send_run(1'b0, 8);
    send_run(1'b1, 2);
    // plain short press
    send_run(1'b0, 2);
    send_run(1'b1, 2);
  endtask

  // test threshold at or below long threshold: long never fires
  task automatic test_test_before_long();
    set_config(12'd1, 12'd1, 12'd6, 12'd2);
    send_run(1'b1, 2);
    send_run(1'b0, 6);
    send_run(1'b1, 2);
  endtask

  // test threshold written below the running hold count
  task automatic test_threshold_lowered();
    set_config(12'd0, 12'd1, 12'd10, 12'd20);
    send_run(1'b1, 4);
    send_run(1'b0, 7);
    set_config(12'd0, 12'd1, 12'd10, 12'd3);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
  endtask

  // writes to unused indexes leave the registers alone
  task automatic test_unused_index();
    settle();
    for (int i = CFG_SPARE_LO; i < (1 << CIDX_W); i++)
      cfg_write(CIDX_W'(i), (i == CFG_SPARE_LO) ? {CDATA_W{1'b1}} : CDATA_W'($urandom));
    cfg_we <= 1'b0;
    send_run(1'b0, 4);
    send_run(1'b1, 3);
  endtask

  // all-zero and all-ones register values
  task automatic test_register_extremes();
    set_config(12'd0, 12'd0, 12'd0, 12'd0);
    send_run(1'b1, 2);
    send_run(1'b0, 4);
    send_run(1'b1, 2);
    set_config(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_run(1'b0, 260);
    set_config(12'd1, 12'hFF, 12'hFFF, 12'hFFF);
    send_run(1'b0, 260);
    send_run(1'b1, 260);
  endtask

  // receiver holds off while ticks keep coming, so the core backs up
  task automatic test_output_backpressure();
    set_config(12'd0, 12'd0, 12'd1, 12'd2);
    hold_off_seq++;
    repeat (15) begin
      send_run(1'b0, 6);
      send_run(1'b1, 2);
    end
  endtask

  // random press sequences with bounce noise under random settings
  task automatic test_random_presses();
    int first_tick;
    int unit;
    int test_eff;
    int max_hold;
    int max_rel;
    logic [CDATA_W-1:0] pre, deb, lng, tst;
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < RANDOM_TICKS) begin
      pre = CDATA_W'($urandom_range(0, 4));
      deb = CDATA_W'(($urandom_range(0, 4) == 0) ? $urandom_range(6, 20)
                                                 : $urandom_range(0, 5));
      lng = CDATA_W'($urandom_range(0, 24));
      tst = ($urandom_range(0, 7) == 0) ? CDATA_W'({THR_W{1'b1}})
                                        : CDATA_W'($urandom_range(0, 32));
      // upper data bits are don't-care for the 8-bit registers
      pre[CDATA_W-1:TICK_W] = (CDATA_W-TICK_W)'($urandom);
      deb[CDATA_W-1:STAB_W] = (CDATA_W-STAB_W)'($urandom);
      set_config(pre, deb, lng, tst);
      if ($urandom_range(0, 5) == 0) begin
        cfg_write(CIDX_W'($urandom_range(CFG_SPARE_LO, (1 << CIDX_W) - 1)),
                  CDATA_W'($urandom));
        cfg_we <= 1'b0;
      end
      unit     = (pre_ticks == 0) ? 1 : pre_ticks;
      test_eff = (test_thr > 40) ? 40 : test_thr;
      max_hold = (deb_scans + test_eff + 6) * unit;
      max_hold = (max_hold > 300) ? 300 : max_hold;
      max_rel  = (deb_scans + 3) * unit;
      max_rel  = (max_rel > 200) ? 200 : max_rel;
      repeat ($urandom_range(3, 8)) begin
        // contact bounce
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 6 * unit)) send_tick(1'($urandom_range(0, 1)));
        send_run(1'b0, $urandom_range(1, max_hold));
        // short release glitch inside the hold
        if ($urandom_range(0, 3) == 0) begin
          send_run(1'b1, $urandom_range(1, (deb_scans + 1) * unit));
          send_run(1'b0, $urandom_range(1, max_hold));
        end
        send_run(1'b1, $urandom_range(1, max_rel));
      end
    end
  endtask

  initial begin
    in_valid     <= 1'b0;
    in_key_level <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_PRESCALE;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    pre_ticks = PRESCALE_RST;
    deb_scans = DEBOUNCE_RST;
    long_thr  = LONG_RST;
    test_thr  = TEST_RST;
    tick_cnt  = '0;
    stab_cnt  = '0;
    hold_cnt  = '0;
    long_flag = 1'b0;
    scan_st   = ST_IDLE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_fast_scan_events();
    test_test_before_long();
    test_threshold_lowered();
    test_unused_index();
    test_register_extremes();
    test_output_backpressure();
    test_random_presses();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_events.size() == 0)
      $display("tb_key_debounce_long_press_core OK");
    else
      $display("tb_key_debounce_long_press_core NOT OK");
    $finish;
  end

endmodule
